// ----- hdl/rect_to_polar_degrees_unit_assert.svh -----
// Assertion macros used by the checker file of the polar converter.
`ifndef RECT_TO_POLAR_DEGREES_UNIT_ASSERT_SVH
`define RECT_TO_POLAR_DEGREES_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define RTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/rtp_pkg.sv -----
// Shared constants and the arctangent table of the polar converter.
package rtp_pkg;

	// Defaults of the top-level parameters
	localparam int COORD_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF    = 8;
	localparam int CORDIC_STEPS_DEF = 18;

	// Angle accumulator: degrees with 16 fraction bits
	localparam int ANG_FRAC       = 16;
	localparam int Z_W            = 27;
	localparam int ATAN_W         = 22;
	localparam int ANGLE_INT_BITS = 9;
	localparam int HALF_TURN_DEG  = 180;
	localparam int FULL_TURN_DEG  = 360;
	localparam int DEG180         = HALF_TURN_DEG << ANG_FRAC;
	localparam int DEG360         = FULL_TURN_DEG << ANG_FRAC;

	// Rotation datapath: coordinates scaled up, with headroom for CORDIC gain
	localparam int GUARD_SHIFT = 24;
	localparam int GROWTH_BITS = 3;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic [ATAN_W-1:0] atan_deg(input int idx);
		logic [ATAN_W-1:0] r;
		case (idx)
			0:  r = ATAN_W'(2949120);
			1:  r = ATAN_W'(1740967);
			2:  r = ATAN_W'(919879);
			3:  r = ATAN_W'(466945);
			4:  r = ATAN_W'(234379);
			5:  r = ATAN_W'(117304);
			6:  r = ATAN_W'(58666);
			7:  r = ATAN_W'(29335);
			8:  r = ATAN_W'(14668);
			9:  r = ATAN_W'(7334);
			10: r = ATAN_W'(3667);
			11: r = ATAN_W'(1833);
			12: r = ATAN_W'(917);
			13: r = ATAN_W'(458);
			14: r = ATAN_W'(229);
			15: r = ATAN_W'(115);
			16: r = ATAN_W'(57);
			17: r = ATAN_W'(29);
			18: r = ATAN_W'(14);
			19: r = ATAN_W'(7);
			20: r = ATAN_W'(4);
			21: r = ATAN_W'(2);
			22: r = ATAN_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/rtp_point_if.sv -----
// Request channel carrying one rectangular point.
interface rtp_point_if #(
	parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] x_coord;
	logic signed [COORD_WIDTH-1:0] y_coord;

	modport source (output valid, x_coord, y_coord, input ready);
	modport sink   (input valid, x_coord, y_coord, output ready);
endinterface

// ----- hdl/rtp_polar_if.sv -----
// Result channel carrying one magnitude and angle pair.
interface rtp_polar_if #(
	parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rtp_pkg::FRAC_BITS_DEF
) ();
	logic                                          valid;
	logic                                          ready;
	logic [COORD_WIDTH-1:0]                        magnitude;
	logic [rtp_pkg::ANGLE_INT_BITS+FRAC_BITS-1:0]  angle_deg;

	modport source (output valid, magnitude, angle_deg, input ready);
	modport sink   (input valid, magnitude, angle_deg, output ready);
endinterface

// ----- hdl/rect_to_polar_degrees_unit.sv -----
// Rectangular-to-polar converter: takes a signed fixed-point point (x, y) and
// returns its magnitude, rounded to the nearest LSB, and its angle atan2(y, x)
// in degrees in [0, 360) with FRAC_BITS fraction bits, within one LSB of the
// exact value. One point is accepted every clock cycle unless a stall at the
// output has filled the pipeline. Three front stages (fold and absolute value,
// squares, sum), one stage per CORDIC micro-rotation or root bit, whichever are
// more, doing the rotation and root bit of its index where these exist, and two
// rounding stages. Each stage has its own ready, so empty stages keep filling
// while a result waits at the output, and a stall drops and repeats nothing.
// Reset clears only the valid bits; no state is kept between points.
module rect_to_polar_degrees_unit #(
	parameter int COORD_WIDTH  = rtp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS    = rtp_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = rtp_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rtp_point_if.sink    point,
	rtp_polar_if.source  polar
);
	localparam int W  = COORD_WIDTH;
	localparam int DW = COORD_WIDTH + rtp_pkg::GUARD_SHIFT + rtp_pkg::GROWTH_BITS;
	localparam int ZW = rtp_pkg::Z_W;
	localparam int ITER_STAGES = (CORDIC_STEPS > COORD_WIDTH) ? CORDIC_STEPS : COORD_WIDTH;

	logic [ITER_STAGES:0] it_valid, it_ready;
	logic signed [DW-1:0] it_cx   [0:ITER_STAGES];
	logic signed [DW-1:0] it_cy   [0:ITER_STAGES];
	logic signed [ZW-1:0] it_z    [0:ITER_STAGES];
	logic [2*W-1:0]       it_rem  [0:ITER_STAGES];
	logic [W-1:0]         it_root [0:ITER_STAGES];

	// front end
	rtp_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (point.valid),
		.in_ready (point.ready),
		.x_coord  (point.x_coord),
		.y_coord  (point.y_coord),
		.out_valid(it_valid[0]),
		.out_ready(it_ready[0]),
		.cx_out   (it_cx[0]),
		.cy_out   (it_cy[0]),
		.z_out    (it_z[0]),
		.rem_out  (it_rem[0])
	);

	assign it_root[0] = '0;

	// rotation and root-digit stages
	for (genvar i = 0; i < ITER_STAGES; i++) begin : g_iter
		rtp_iter_stage #(
			.COORD_WIDTH (COORD_WIDTH),
			.CORDIC_STEPS(CORDIC_STEPS),
			.INDEX       (i)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (it_valid[i]),
			.in_ready (it_ready[i]),
			.cx_in    (it_cx[i]),
			.cy_in    (it_cy[i]),
			.z_in     (it_z[i]),
			.rem_in   (it_rem[i]),
			.root_in  (it_root[i]),
			.out_valid(it_valid[i+1]),
			.out_ready(it_ready[i+1]),
			.cx_out   (it_cx[i+1]),
			.cy_out   (it_cy[i+1]),
			.z_out    (it_z[i+1]),
			.rem_out  (it_rem[i+1]),
			.root_out (it_root[i+1])
		);
	end

	// rounding and output register
	rtp_back #(
		.COORD_WIDTH(COORD_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (it_valid[ITER_STAGES]),
		.in_ready (it_ready[ITER_STAGES]),
		.z_in     (it_z[ITER_STAGES]),
		.rem_in   (it_rem[ITER_STAGES]),
		.root_in  (it_root[ITER_STAGES]),
		.out_valid(polar.valid),
		.out_ready(polar.ready),
		.magnitude(polar.magnitude),
		.angle_deg(polar.angle_deg)
	);
endmodule

// ----- hdl/rtp_front.sv -----
// Front end: absolute values, half-plane fold, squares and their sum.
module rtp_front #(
	parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_WIDTH-1:0]         x_coord,
	input  logic signed [COORD_WIDTH-1:0]         y_coord,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [COORD_WIDTH+rtp_pkg::GUARD_SHIFT+rtp_pkg::GROWTH_BITS-1:0] cx_out,
	output logic signed [COORD_WIDTH+rtp_pkg::GUARD_SHIFT+rtp_pkg::GROWTH_BITS-1:0] cy_out,
	output logic signed [rtp_pkg::Z_W-1:0]        z_out,
	output logic        [2*COORD_WIDTH-1:0]       rem_out
);
	localparam int W  = COORD_WIDTH;
	localparam int DW = COORD_WIDTH + rtp_pkg::GUARD_SHIFT + rtp_pkg::GROWTH_BITS;
	localparam int ZW = rtp_pkg::Z_W;

	logic en1, en2, en3;
	logic valid_s1, valid_s2, valid_s3;

	logic                 x_neg;
	logic [W-1:0]         ax_n, ay_n;
	logic signed [DW-1:0] xe, ye, cx_n, cy_n;
	logic [2*W-1:0]       sqx_n, sqy_n;

	logic [W-1:0]         ax_s1, ay_s1;
	logic signed [DW-1:0] cx_s1, cy_s1, cx_s2, cy_s2, cx_s3, cy_s3;
	logic signed [ZW-1:0] z_s1, z_s2, z_s3;
	logic [2*W-1:0]       sqx_s2, sqy_s2, rem_s3;

	// per-stage ready: a stage loads when empty or when its successor moves
	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// stage 1: magnitudes of the coordinates, fold left half plane onto right
	always_comb begin
		x_neg = x_coord[W-1];
		ax_n  = x_coord[W-1] ? (~x_coord + W'(1)) : x_coord;
		ay_n  = y_coord[W-1] ? (~y_coord + W'(1)) : y_coord;
		xe    = DW'(x_coord);
		ye    = DW'(y_coord);
		cx_n  = (x_neg ? -xe : xe) <<< rtp_pkg::GUARD_SHIFT;
		cy_n  = (x_neg ? -ye : ye) <<< rtp_pkg::GUARD_SHIFT;
	end

	// stage 2: squares
	assign sqx_n = (2*W)'(ax_s1) * (2*W)'(ax_s1);
	assign sqy_n = (2*W)'(ay_s1) * (2*W)'(ay_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ax_s1 <= ax_n;
			ay_s1 <= ay_n;
			cx_s1 <= cx_n;
			cy_s1 <= cy_n;
			z_s1  <= x_neg ? ZW'(rtp_pkg::DEG180) : '0;
		end
		if (en2) begin
			sqx_s2 <= sqx_n;
			sqy_s2 <= sqy_n;
			cx_s2  <= cx_s1;
			cy_s2  <= cy_s1;
			z_s2   <= z_s1;
		end
		// stage 3: sum of squares seeds the root extraction
		if (en3) begin
			rem_s3 <= sqx_s2 + sqy_s2;
			cx_s3  <= cx_s2;
			cy_s3  <= cy_s2;
			z_s3   <= z_s2;
		end
	end

	assign out_valid = valid_s3;
	assign cx_out    = cx_s3;
	assign cy_out    = cy_s3;
	assign z_out     = z_s3;
	assign rem_out   = rem_s3;
endmodule

// ----- hdl/rtp_iter_stage.sv -----
// One pipeline stage: a vectoring micro-rotation and one square-root digit, each where its index is in range.
module rtp_iter_stage #(
	parameter int COORD_WIDTH  = rtp_pkg::COORD_WIDTH_DEF,
	parameter int CORDIC_STEPS = rtp_pkg::CORDIC_STEPS_DEF,
	parameter int INDEX        = 0
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_WIDTH+rtp_pkg::GUARD_SHIFT+rtp_pkg::GROWTH_BITS-1:0] cx_in,
	input  logic signed [COORD_WIDTH+rtp_pkg::GUARD_SHIFT+rtp_pkg::GROWTH_BITS-1:0] cy_in,
	input  logic signed [rtp_pkg::Z_W-1:0]        z_in,
	input  logic        [2*COORD_WIDTH-1:0]       rem_in,
	input  logic        [COORD_WIDTH-1:0]         root_in,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [COORD_WIDTH+rtp_pkg::GUARD_SHIFT+rtp_pkg::GROWTH_BITS-1:0] cx_out,
	output logic signed [COORD_WIDTH+rtp_pkg::GUARD_SHIFT+rtp_pkg::GROWTH_BITS-1:0] cy_out,
	output logic signed [rtp_pkg::Z_W-1:0]        z_out,
	output logic        [2*COORD_WIDTH-1:0]       rem_out,
	output logic        [COORD_WIDTH-1:0]         root_out
);
	localparam int W       = COORD_WIDTH;
	localparam int DW      = COORD_WIDTH + rtp_pkg::GUARD_SHIFT + rtp_pkg::GROWTH_BITS;
	localparam int ZW      = rtp_pkg::Z_W;
	localparam bit DO_ROT  = (INDEX < CORDIC_STEPS);
	localparam bit DO_SQRT = (INDEX < COORD_WIDTH);
	localparam int SQ_BIT  = DO_SQRT ? (COORD_WIDTH - 1 - INDEX) : 0;
	localparam logic signed [ZW-1:0] ATAN_STEP = ZW'(rtp_pkg::atan_deg(INDEX));

	logic                 en;
	logic                 valid_s1;
	logic signed [DW-1:0] cx_n, cy_n, cx_s1, cy_s1;
	logic signed [ZW-1:0] z_n, z_s1;
	logic [2*W-1:0]       trial, rem_n, rem_s1;
	logic                 take;
	logic [W-1:0]         root_n, root_s1;

	assign en       = !valid_s1 || out_ready;
	assign in_ready = en;

	// micro-rotation toward the x axis; a point already on the axis passes
	always_comb begin
		cx_n = cx_in;
		cy_n = cy_in;
		z_n  = z_in;
		if (DO_ROT && (cy_in != '0)) begin
			if (!cy_in[DW-1]) begin
				cx_n = cx_in + (cy_in >>> INDEX);
				cy_n = cy_in - (cx_in >>> INDEX);
				z_n  = z_in + ATAN_STEP;
			end else begin
				cx_n = cx_in - (cy_in >>> INDEX);
				cy_n = cy_in + (cx_in >>> INDEX);
				z_n  = z_in - ATAN_STEP;
			end
		end
	end

	// restoring square root: try setting root bit SQ_BIT
	always_comb begin
		trial  = ((2*W)'(root_in) << (SQ_BIT + 1)) | ((2*W)'(1) << (2 * SQ_BIT));
		take   = DO_SQRT && (rem_in >= trial);
		rem_n  = take ? (rem_in - trial) : rem_in;
		root_n = take ? (root_in | (W'(1) << SQ_BIT)) : root_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1   <= cx_n;
			cy_s1   <= cy_n;
			z_s1    <= z_n;
			rem_s1  <= rem_n;
			root_s1 <= root_n;
		end
	end

	assign out_valid = valid_s1;
	assign cx_out    = cx_s1;
	assign cy_out    = cy_s1;
	assign z_out     = z_s1;
	assign rem_out   = rem_s1;
	assign root_out  = root_s1;
endmodule

// ----- hdl/rtp_back.sv -----
// Back end: rounding of the root and of the angle, wrap of a full turn.
module rtp_back #(
	parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rtp_pkg::FRAC_BITS_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [rtp_pkg::Z_W-1:0]                z_in,
	input  logic        [2*COORD_WIDTH-1:0]               rem_in,
	input  logic        [COORD_WIDTH-1:0]                 root_in,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [COORD_WIDTH-1:0]                        magnitude,
	output logic [rtp_pkg::ANGLE_INT_BITS+FRAC_BITS-1:0]  angle_deg
);
	localparam int W    = COORD_WIDTH;
	localparam int ZW   = rtp_pkg::Z_W;
	localparam int SH   = rtp_pkg::ANG_FRAC - FRAC_BITS;
	localparam int HALF = (SH > 0) ? (1 << (SH - 1)) : 0;
	localparam int TW   = ZW - SH;
	localparam int AW   = rtp_pkg::ANGLE_INT_BITS + FRAC_BITS;
	localparam logic [TW-1:0] FULL = TW'(rtp_pkg::FULL_TURN_DEG << FRAC_BITS);

	logic en1, en2;
	logic valid_s1, valid_s2;

	logic [ZW-1:0] zadj_n, zadj_s1;
	logic [W:0]    mag_sum;
	logic [W-1:0]  mag_s1, mag_s2;
	logic [TW-1:0] turn, wrapped;
	logic [AW-1:0] angle_s2;

	assign en2      = !valid_s2 || out_ready;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// stage 1: bring negative angles into range, add half an output LSB;
	// round the root up when the remainder exceeds it
	always_comb begin
		zadj_n  = z_in + (z_in[ZW-1] ? ZW'(rtp_pkg::DEG360) : '0) + ZW'(HALF);
		mag_sum = {1'b0, root_in} + (W+1)'(rem_in > (2*W)'(root_in));
	end

	// stage 2: drop fraction bits, a rounded full turn reads as zero
	always_comb begin
		turn    = zadj_s1[ZW-1:SH];
		wrapped = (turn >= FULL) ? (turn - FULL) : turn;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			zadj_s1 <= zadj_n;
			mag_s1  <= mag_sum[W-1:0];
		end
		if (en2) begin
			angle_s2 <= wrapped[AW-1:0];
			mag_s2   <= mag_s1;
		end
	end

	assign out_valid = valid_s2;
	assign magnitude = mag_s2;
	assign angle_deg = angle_s2;
endmodule

// ----- hdl/rtp_checker.sv -----
// Port-level checks of the polar converter's result channel, bound to the top.
`include "rect_to_polar_degrees_unit_assert.svh"

module rtp_checker #(
	parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = rtp_pkg::FRAC_BITS_DEF
) (
	input logic                                          clk,
	input logic                                          arst_n,
	input logic                                          out_valid,
	input logic                                          out_ready,
	input logic [COORD_WIDTH-1:0]                        magnitude,
	input logic [rtp_pkg::ANGLE_INT_BITS+FRAC_BITS-1:0]  angle_deg
);
	localparam int AW = rtp_pkg::ANGLE_INT_BITS + FRAC_BITS;
	localparam logic [AW-1:0] FULL = AW'(rtp_pkg::FULL_TURN_DEG << FRAC_BITS);

	// a result under backpressure stays offered
	`RTP_ASSERT_NEXT(a_hold_valid, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// and keeps its payload
	`RTP_ASSERT_NEXT(a_hold_data, clk, arst_n, out_valid && !out_ready, $stable(magnitude) && $stable(angle_deg), "result changed while stalled")

	// the angle never reaches a full turn
	`RTP_ASSERT_NOW(a_angle_range, clk, arst_n, out_valid, angle_deg < FULL, "angle at or above 360 degrees")

	// zero magnitude only comes from the origin, whose angle is zero
	`RTP_ASSERT_NOW(a_origin_angle, clk, arst_n, out_valid && (magnitude == '0), angle_deg == '0, "origin with nonzero angle")
endmodule

bind rect_to_polar_degrees_unit rtp_checker #(
	.COORD_WIDTH(COORD_WIDTH),
	.FRAC_BITS  (FRAC_BITS)
) u_rtp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(polar.valid),
	.out_ready(polar.ready),
	.magnitude(polar.magnitude),
	.angle_deg(polar.angle_deg)
);
